// File: design/ddrm_pkg.sv
`default_nettype none
package ddrm_pkg;
  localparam logic [1:0] FUNC_POST = 2'd0;
  localparam logic [1:0] FUNC_POLL = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  localparam logic [1:0] KIND_DESC = 2'd0;
  localparam logic [1:0] KIND_DOORBELL = 2'd1;
  localparam logic [1:0] KIND_POLL = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NOT_ENABLED = 3'd1;
  localparam logic [2:0] ST_RING_FULL = 3'd2;
  localparam logic [2:0] ST_TOO_MANY = 3'd3;
  localparam logic [2:0] ST_NONE = 3'd4;

  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_SIZE = 3'd1;
  localparam logic [2:0] REG_CHUNK = 3'd2;
  localparam logic [2:0] REG_BASE = 3'd3;
  localparam logic [2:0] REG_TIMEOUT = 3'd4;

  localparam logic [16:0] LOCAL_CHUNK = 17'd64;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  opcode;
    logic [63:0] src_address;
    logic [63:0] dst_address;
    logic [15:0] length;
    logic        with_callback;
    logic        comp_color;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  desc_opcode;
    logic [15:0] desc_len;
    logic [63:0] desc_src;
    logic [63:0] desc_dst;
    logic [9:0]  slot;
    logic [9:0]  head_index;
    logic [2:0]  status;
    logic        callback_due;
    logic        timed_out;
    logic        last;
  } result_t;

  // one write into the entry tables
  typedef struct packed {
    logic        en;
    logic [15:0] addr;
    logic        callback;
    logic [31:0] deadline;
    logic        wr_deadline;
  } entry_wr_t;
endpackage
`default_nettype wire

// File: design/ddrm_entry_mem.sv
`default_nettype none
module ddrm_entry_mem import ddrm_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW = 10
) (
  input  wire logic            clk,
  input  wire entry_wr_t       wr,
  input  wire logic [AW-1:0]   rd_addr,
  output logic                 rd_callback,
  output logic [31:0]          rd_deadline
);
  logic        cb_mem [DEPTH];
  logic [31:0] dl_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      cb_mem[wr.addr[AW-1:0]] <= wr.callback;
      if (wr.wr_deadline) begin
        dl_mem[wr.addr[AW-1:0]] <= wr.deadline;
      end
    end
    rd_callback <= cb_mem[rd_addr];
    rd_deadline <= dl_mem[rd_addr];
  end
endmodule
`default_nettype wire

// File: design/dma_descriptor_ring_manager.sv
`default_nettype none
// Post: a check state, then one descriptor per cycle, doorbell after the last;
//   a post rejected at the check gives only a doorbell result with its status.
// Poll: entry memory read (S_POLL_RD), then decide (S_POLL).
// Tick: advances time. Results are strobed for one cycle; the receiver cannot stall.
// Synchronous active-high reset clears pointers and time, sets the color to 1 and the
// registers to their defaults; the entry tables are not cleared.
module dma_descriptor_ring_manager import ddrm_pkg::*; #(
  parameter int RING_DEPTH = 1024,
  parameter int MAX_CHUNKS = 63
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire cmd_t    cmd,
  output logic         result_valid,
  output result_t      result,
  input  wire logic    cfg_valid,
  output logic         cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int LW = $clog2(RING_DEPTH) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_EMIT = 3'd2;
  localparam logic [2:0] S_POLL_RD = 3'd3;
  localparam logic [2:0] S_POLL = 3'd4;

  logic [2:0] state;
  logic       queue_enabled;
  logic [3:0] ring_size_log2;
  logic [4:0] chunk_log2;
  logic [63:0] local_base;
  logic [31:0] timeout_ticks;
  logic [AW-1:0] head, tail;
  logic expected_color;
  logic [31:0] now;
  cmd_t req;

  logic [16:0] chunk;
  logic [4:0]  cshift;
  logic [15:0] off;
  logic [AW-1:0] h;

  entry_wr_t wr;
  logic [AW-1:0] rd_addr;
  logic rd_cb;
  logic [31:0] rd_dl;

  ddrm_entry_mem #(.DEPTH(RING_DEPTH), .AW(AW)) u_mem (
    .clk(clk), .wr(wr), .rd_addr(rd_addr),
    .rd_callback(rd_cb), .rd_deadline(rd_dl)
  );

  assign cfg_ready = 1'b1;
  assign busy = (state != S_IDLE);

  // ring size saturates at RING_DEPTH
  logic [LW-1:0] lsize;
  always_comb begin
    if (32'(ring_size_log2) >= 32'(LW - 1)) lsize = LW'(LW - 1);
    else lsize = LW'(ring_size_log2);
  end
  logic [AW:0] size_mask_w;
  assign size_mask_w = ((AW+1)'(1) << lsize) - (AW+1)'(1);
  logic [AW-1:0] mask;
  assign mask = size_mask_w[AW-1:0];
  logic [AW-1:0] head_m, tail_m;
  assign head_m = head & mask;
  assign tail_m = tail & mask;

  logic [AW-1:0] used;
  logic [AW:0]   freeslots;
  assign used = (head_m - tail_m) & mask;
  assign freeslots = size_mask_w - {1'b0, used};

  logic [4:0] cl_eff;
  assign cl_eff = (chunk_log2 > 5'd16) ? 5'd16 : chunk_log2;
  logic local_hit;
  assign local_hit = (cmd.src_address <= local_base) || (cmd.dst_address <= local_base);

  logic [16:0] nchunks;
  logic [16:0] lenx;
  assign lenx = {1'b0, req.length} + chunk - 17'd1;
  assign nchunks = lenx >> cshift;

  logic [15:0] left;
  logic [16:0] leftx;
  logic fin;
  assign left = req.length - off;
  assign leftx = {1'b0, left};
  assign fin = (leftx <= chunk);

  logic [31:0] diff;
  logic late, match;
  logic [AW-1:0] tail_inc;
  assign diff = now - rd_dl;
  assign late = (diff != 32'd0) && !diff[31];
  assign match = (req.comp_color == expected_color);
  assign tail_inc = (tail_m + AW'(1)) & mask;

  always_comb begin
    wr = '0;
    rd_addr = tail_m;
    if (state == S_EMIT && off < req.length) begin
      wr.en = 1'b1;
      wr.addr = 16'(h);
      wr.callback = fin & req.with_callback;
      wr.deadline = now + timeout_ticks;
      wr.wr_deadline = 1'b1;
    end else if (state == S_POLL && head != tail && (match || late)) begin
      wr.en = 1'b1;
      wr.addr = 16'(tail);
    end
  end

  always_ff @(posedge clk) begin
    result_t res;
    logic    res_valid;
    res = result;
    res_valid = 1'b0;
    if (rst) begin
      state <= S_IDLE;
      queue_enabled <= 1'b0;
      ring_size_log2 <= 4'd10;
      chunk_log2 <= 5'd12;
      local_base <= '0;
      timeout_ticks <= 32'd1000;
      head <= '0;
      tail <= '0;
      expected_color <= 1'b1;
      now <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_ENABLE:  queue_enabled <= cfg_data[0];
          REG_SIZE:    ring_size_log2 <= cfg_data[3:0];
          REG_CHUNK:   chunk_log2 <= cfg_data[4:0];
          REG_BASE:    local_base <= cfg_data;
          REG_TIMEOUT: timeout_ticks <= cfg_data[31:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            req <= cmd;
            head <= head_m;
            tail <= tail_m;
            if (local_hit && cl_eff > 5'd6) begin
              cshift <= 5'd6;
              chunk <= LOCAL_CHUNK;
            end else begin
              cshift <= cl_eff;
              chunk <= 17'd1 << cl_eff;
            end
            off <= '0;
            if (cmd.func == FUNC_POST) state <= S_CHECK;
            else if (cmd.func == FUNC_POLL) state <= S_POLL_RD;
            else if (cmd.func == FUNC_TICK) now <= now + 32'd1;
          end
        end
        S_CHECK: begin
          h <= head;
          res = '0;
          res.kind = KIND_DOORBELL;
          res.head_index = 10'(head);
          res.last = 1'b1;
          if (!queue_enabled) begin
            res.status = ST_NOT_ENABLED;
            res_valid = 1'b1;
            state <= S_IDLE;
          end else if (nchunks > 17'(MAX_CHUNKS)) begin
            res.status = ST_TOO_MANY;
            res_valid = 1'b1;
            state <= S_IDLE;
          end else if (nchunks > 17'(freeslots)) begin
            res.status = ST_RING_FULL;
            res_valid = 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          res = '0;
          res_valid = 1'b1;
          if (off < req.length) begin
            res.kind = KIND_DESC;
            res.desc_opcode = req.opcode;
            res.desc_len = fin ? left : chunk[15:0];
            res.desc_src = req.src_address + 64'(off);
            res.desc_dst = req.dst_address + 64'(off);
            res.slot = 10'(h);
            res.callback_due = fin & req.with_callback;
            off <= fin ? req.length : off + chunk[15:0];
            h <= (h + AW'(1)) & mask;
          end else begin
            res.kind = KIND_DOORBELL;
            res.head_index = 10'(h);
            res.last = 1'b1;
            head <= h;
            state <= S_IDLE;
          end
        end
        S_POLL_RD: state <= S_POLL;
        S_POLL: begin
          res = '0;
          res_valid = 1'b1;
          res.kind = KIND_POLL;
          res.last = 1'b1;
          if (head == tail || !(match || late)) begin
            res.status = ST_NONE;
          end else begin
            res.slot = 10'(tail);
            res.callback_due = rd_cb;
            res.timed_out = !match && late;
            tail <= tail_inc;
            if (tail_inc == '0) expected_color <= ~expected_color;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
    result <= res;
    result_valid <= res_valid;
  end
endmodule
`default_nettype wire

// File: bench/tb_dma_descriptor_ring_manager.sv
`timescale 1ns / 1ps
module tb_dma_descriptor_ring_manager;
  import ddrm_pkg::*;

  localparam int DEPTH = 1024;
  localparam int CHUNK_CAP = 63;
  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd = '0;
  logic result_valid;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  dma_descriptor_ring_manager dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // shadow of the ring manager
  int m_enable, m_size_log2, m_chunk_log2, m_timeout;
  logic [63:0] m_base;
  int m_head, m_tail;
  logic m_color;
  logic [31:0] m_now;
  logic ent_cb [DEPTH];
  logic [31:0] ent_dl [DEPTH];

  cmd_t pend_cmds[$];
  result_t ring_results[$];
  int idle_pct = 0;
  int errors = 0;
  int results_seen = 0;
  int posts_sent = 0;
  int polls_sent = 0;
  int cyc = 0;

  function automatic int ring_slots();
    int s;
    s = 1 << m_size_log2;
    return (s > DEPTH) ? DEPTH : s;
  endfunction

  function automatic int chunk_bytes(logic [63:0] src, logic [63:0] dst);
    int c;
    c = 1 << ((m_chunk_log2 > 16) ? 16 : m_chunk_log2);
    if ((src <= m_base || dst <= m_base) && c > 64) c = 64;
    return c;
  endfunction

  task automatic predict_ring(cmd_t c);
    int size, chunk, nch, used, free_slots, off, h, left, t;
    logic [31:0] diff;
    logic late, oldc;
    result_t r;
    size = ring_slots();
    m_head = m_head % size;
    m_tail = m_tail % size;
    r = '0;
    r.last = 1'b1;
    if (c.func == FUNC_POST) begin
      r.kind = KIND_DOORBELL;
      r.head_index = m_head[9:0];
      chunk = chunk_bytes(c.src_address, c.dst_address);
      nch = (int'(c.length) + chunk - 1) / chunk;
      used = (m_head + size - m_tail) % size;
      free_slots = size - 1 - used;
      if (m_enable == 0) r.status = ST_NOT_ENABLED;
      else if (nch > CHUNK_CAP) r.status = ST_TOO_MANY;
      else if (nch > free_slots) r.status = ST_RING_FULL;
      else begin
        off = 0;
        h = m_head;
        while (off < int'(c.length)) begin
          result_t d;
          left = int'(c.length) - off;
          t = (left <= chunk) ? left : chunk;
          d = '0;
          d.kind = KIND_DESC;
          d.desc_opcode = c.opcode;
          d.desc_len = t[15:0];
          d.desc_src = c.src_address + 64'(off);
          d.desc_dst = c.dst_address + 64'(off);
          d.slot = h[9:0];
          d.callback_due = (left <= chunk) ? c.with_callback : 1'b0;
          ent_cb[h] = d.callback_due;
          ent_dl[h] = m_now + 32'(m_timeout);
          ring_results.push_back(d);
          h = (h + 1) % size;
          off += t;
        end
        m_head = h;
        r.head_index = m_head[9:0];
        r.status = ST_OK;
      end
      ring_results.push_back(r);
    end else if (c.func == FUNC_POLL) begin
      r.kind = KIND_POLL;
      r.status = ST_NONE;
      if (m_head != m_tail) begin
        diff = m_now - ent_dl[m_tail];
        late = (diff != 0 && diff < 32'h8000_0000);
        if (c.comp_color == m_color || late) begin
          oldc = m_color;
          r.status = ST_OK;
          r.slot = m_tail[9:0];
          r.callback_due = ent_cb[m_tail];
          ent_cb[m_tail] = 1'b0;
          m_tail = (m_tail + 1) % size;
          if (m_tail == 0) m_color = ~m_color;
          r.timed_out = (c.comp_color != oldc) ? late : 1'b0;
        end
      end
      ring_results.push_back(r);
    end else if (c.func == FUNC_TICK) begin
      m_now = m_now + 32'd1;
    end
  endtask

  task automatic send(cmd_t c);
    if (c.func == FUNC_POST) posts_sent++;
    if (c.func == FUNC_POLL) polls_sent++;
    predict_ring(c);
    pend_cmds.push_back(c);
  endtask

  function automatic cmd_t make_post(logic [3:0] op, logic [63:0] src, logic [63:0] dst,
                                     int len, logic cb);
    cmd_t c;
    c = '0;
    c.func = FUNC_POST;
    c.opcode = op;
    c.src_address = src;
    c.dst_address = dst;
    c.length = len[15:0];
    c.with_callback = cb;
    c.comp_color = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic cmd_t make_other(logic [1:0] f, logic color);
    cmd_t c;
    c = '0;
    c.func = f;
    c.opcode = 4'($urandom_range(0, 15));
    c.src_address = {$urandom, $urandom};
    c.dst_address = {$urandom, $urandom};
    c.length = 16'($urandom_range(0, 65535));
    c.with_callback = 1'($urandom_range(0, 1));
    c.comp_color = color;
    return c;
  endfunction

  function automatic logic [63:0] rand_addr();
    case ($urandom_range(0, 3))
      0: return m_base - 64'($urandom_range(0, 3));
      1: return m_base + 64'($urandom_range(1, 3));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_items(int count);
    int k, chunk, len;
    logic [63:0] s, d;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: begin
          s = rand_addr();
          d = rand_addr();
          chunk = chunk_bytes(s, d);
          case ($urandom_range(0, 9))
            0: len = $urandom_range(0, 65535);
            1: len = $urandom_range(0, chunk);
            default: len = $urandom_range(0, chunk * 5);
          endcase
          if (len > 65535) len = 65535;
          send(make_post(4'($urandom_range(0, 15)), s, d, len, 1'($urandom_range(0, 1))));
        end
        9, 10, 11, 12, 13, 14:
          send(make_other(FUNC_POLL, ($urandom_range(0, 3) == 0) ? 1'($urandom) : m_color));
        15, 16, 17, 18: send(make_other(FUNC_TICK, 1'($urandom_range(0, 1))));
        default: begin
          pend_cmds.push_back(make_other(2'd3, 1'($urandom_range(0, 1))));
          k--;
        end
      endcase
    end
  endtask

  // complete everything outstanding so the ring size can change safely
  task automatic drain_ring();
    while (m_head % ring_slots() != m_tail % ring_slots())
      send(make_other(FUNC_POLL, m_color));
  endtask

  task automatic settle();
    while (pend_cmds.size() != 0 || start || busy || ring_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ENABLE: m_enable = int'(val[0]);
      REG_SIZE: m_size_log2 = int'(val[3:0]);
      REG_CHUNK: m_chunk_log2 = int'(val[4:0]);
      REG_BASE: m_base = val;
      REG_TIMEOUT: m_timeout = int'(val[31:0]);
      default: ;
    endcase
  endtask

  task automatic setup(int en, int sz, int ch, logic [63:0] base, logic [31:0] to);
    write_reg(REG_ENABLE, 64'(en));
    write_reg(REG_SIZE, 64'(sz));
    write_reg(REG_CHUNK, 64'(ch));
    write_reg(REG_BASE, base);
    write_reg(REG_TIMEOUT, 64'(to));
  endtask

  // driver: hold start until the transfer, then present the next command
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (pend_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        cmd <= pend_cmds.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      results_seen++;
      if (ring_results.size() == 0) begin
        $display("%0t: unexpected result expected none actual %p", $time, result);
        errors++;
      end else begin
        result_t e;
        e = ring_results.pop_front();
        check_field("kind", 64'(e.kind), 64'(result.kind));
        check_field("desc_opcode", 64'(e.desc_opcode), 64'(result.desc_opcode));
        check_field("desc_len", 64'(e.desc_len), 64'(result.desc_len));
        check_field("desc_src", e.desc_src, result.desc_src);
        check_field("desc_dst", e.desc_dst, result.desc_dst);
        check_field("slot", 64'(e.slot), 64'(result.slot));
        check_field("head_index", 64'(e.head_index), 64'(result.head_index));
        check_field("status", 64'(e.status), 64'(result.status));
        check_field("callback_due", 64'(e.callback_due), 64'(result.callback_due));
        check_field("timed_out", 64'(e.timed_out), 64'(result.timed_out));
        check_field("last", 64'(e.last), 64'(result.last));
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("dma_descriptor_ring_manager: mismatch");
      $finish;
    end
  end

  initial begin
    int i;
    m_enable = 0;
    m_size_log2 = 10;
    m_chunk_log2 = 12;
    m_base = '0;
    m_timeout = 1000;
    m_head = 0;
    m_tail = 0;
    m_color = 1'b1;
    m_now = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // disabled queue: post rejected, empty poll, tick, ignored func
    send(make_post(4'hF, '1, '1, 65535, 1'b1));
    send(make_other(FUNC_POLL, 1'b1));
    send(make_other(FUNC_TICK, 1'b0));
    pend_cmds.push_back(make_other(2'd3, 1'b1));
    settle();

    setup(1, 2, 6, 64'h1000, 3);
    send(make_post(4'h0, 64'h2000, 64'h3000, 0, 1'b1));
    send(make_post(4'h5, 64'h2000, 64'h3000, 64, 1'b1));
    send(make_post(4'hA, 64'h0, 64'h1000, 65535, 1'b0));
    send(make_post(4'h3, 64'hFFFF_FFFF_FFFF_FFC0, 64'h4000, 65, 1'b1));
    send(make_post(4'h7, 64'h2000, 64'h3000, 10, 1'b0));
    send(make_other(FUNC_POLL, 1'b0));
    for (i = 0; i < 5; i++) send(make_other(FUNC_TICK, 1'b0));
    send(make_other(FUNC_POLL, 1'b0));
    send(make_other(FUNC_POLL, 1'b1));
    send(make_other(FUNC_POLL, 1'b0));
    drain_ring();
    send(make_other(FUNC_POLL, 1'b1));
    settle();

    // size zero: a one-slot ring, so every non-empty post is full
    setup(1, 0, 16, 64'h0, 32'd0);
    send(make_post(4'h1, 64'h10, 64'h20, 1, 1'b1));
    send(make_post(4'h1, 64'h10, 64'h20, 0, 1'b1));
    send(make_other(FUNC_POLL, 1'b1));
    settle();

    idle_pct = 21;
    setup(1, 10, 12, 64'h0, 32'd1000);
    random_items(25);
    drain_ring();
    settle();

    idle_pct = 74;
    setup(1, 15, 31, '1, 32'd0);
    random_items(22);
    drain_ring();
    settle();

    idle_pct = 0;
    setup(1, 3, 0, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF);
    random_items(15);
    drain_ring();
    settle();

    setup(1, 1, 8, 64'h100, 32'd2);
    random_items(15);
    drain_ring();
    settle();

    setup(0, 10, 12, 64'h0, 32'd1000);
    random_items(8);
    settle();

    $display("covered %0d posts and %0d polls over several ring, chunk and timeout settings",
             posts_sent, polls_sent);
    $display("checked %0d results", results_seen);
    if (errors == 0 && ring_results.size() == 0) begin
      $display("dma_descriptor_ring_manager: match");
    end else begin
      $display("dma_descriptor_ring_manager: mismatch");
    end
    $finish;
  end
endmodule

// File: sim.f
design/ddrm_pkg.sv
design/ddrm_entry_mem.sv
design/dma_descriptor_ring_manager.sv
bench/tb_dma_descriptor_ring_manager.sv
